// ===== rtl/shl_pkg.sv =====
// Types, codes and defaults shared by the sorted hit list files.
package shl_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int READ_SPAN        = 16;

   localparam logic [1:0] FN_INSERT = 2'd0;
   localparam logic [1:0] FN_READ   = 2'd1;
   localparam logic [1:0] FN_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] distance;
      logic [15:0]        shape_id;
      logic [3:0]         read_index;
   } req_type;

   typedef struct packed {
      logic               hit_valid;
      logic signed [31:0] hit_distance;
      logic [15:0]        hit_shape;
      logic [4:0]         entry_count;
      logic signed [31:0] entry_distance;
      logic [15:0]        entry_shape;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic [15:0]        shape_id;
   } entry_type;

   // What one cell hands to the next one down the chain.
   typedef struct packed {
      entry_type entry;
      logic      gt;
   } cell_link_type;

   typedef struct packed {
      logic load;
      logic occupied;
   } cell_ctrl_type;

   typedef struct packed {
      logic update;
      logic clear;
   } hit_ctrl_type;

   typedef struct packed {
      logic               present;
      logic signed [31:0] distance;
      logic [15:0]        shape_id;
   } hit_type;

endpackage

// ===== rtl/shl_cell.sv =====
// One slot of the sorted chain: compares, keeps, loads the new word or shifts.
module shl_cell (
   input  logic                   clock,
   input  shl_pkg::cell_ctrl_type ctrl,
   input  shl_pkg::entry_type     new_entry,
   input  shl_pkg::cell_link_type left,
   output shl_pkg::cell_link_type right
);

   shl_pkg::entry_type entry_ff;
   shl_pkg::entry_type entry_in;
   logic               gt;

   assign gt = ctrl.occupied &&
               ($signed(new_entry.distance) > $signed(entry_ff.distance));

   // A smaller stored entry stays; the first slot not smaller takes the new
   // word, and every slot after it takes its left neighbor.
   always_comb begin
      priority if (gt) begin
         entry_in = entry_ff;
      end else if (left.gt) begin
         entry_in = new_entry;
      end else begin
         entry_in = left.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         entry_ff <= entry_in;
      end
   end

   assign right.entry = entry_ff;
   assign right.gt    = gt;

endmodule

// ===== rtl/shl_hit_track.sv =====
// Tracks the smallest strictly positive distance and its shape.
module shl_hit_track (
   input  logic                  clock,
   input  logic                  reset,
   input  shl_pkg::hit_ctrl_type ctrl,
   input  shl_pkg::entry_type    new_entry,
   output shl_pkg::hit_type      hit_next
);

   shl_pkg::hit_type hit_ff;
   shl_pkg::hit_type hit_in;
   logic             better;

   // Only a strictly smaller distance replaces the hit, so the first of equals wins.
   assign better = ($signed(new_entry.distance) > 32'sd0) &&
                   (!hit_ff.present ||
                    ($signed(new_entry.distance) < $signed(hit_ff.distance)));

   always_comb begin
      priority if (ctrl.clear) begin
         hit_in = '0;
      end else if (ctrl.update && better) begin
         hit_in.present  = 1'b1;
         hit_in.distance = new_entry.distance;
         hit_in.shape_id = new_entry.shape_id;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit_next = hit_in;

endmodule

// ===== rtl/sorted_hit_list_unit.sv =====
// Top level of the sorted hit list: request decode, cell chain, read select, result register.
//
// The request channel carries one word per intersection command: insert a
// distance and shape, read the entry at an index, or clear the list and hit.
// Every request gives exactly one word on the result channel with the hit,
// the entry count after the command, the read entry and the overflow flag.
// An insert goes to a chain of CAPACITY cells; each cell compares the new
// distance with its own entry and in the same cycle keeps it, loads the new
// word or takes its left neighbor, so the list stays in ascending order.
// The result word is registered at the edge that takes the request.
// Throughput is one request per cycle while the receiver does not stall, as
// the compare and shift in the cell chain need no register of their own.
// The result register lets a new request in whenever it is empty or being
// taken; while the receiver stalls, req_ready stays low and nothing changes.
// Reset empties the list and clears the hit; stored entries are
// not cleared, since only the fill count decides which cells are read.
// Reads reach the first sixteen positions only, as the index has four bits.
module sorted_hit_list_unit #(
   parameter int CAPACITY = shl_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shl_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int RD_N  = (CAPACITY < shl_pkg::READ_SPAN) ? CAPACITY : shl_pkg::READ_SPAN;
   localparam int EXT_W = CNT_W + 4;

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   shl_pkg::rsp_type       rsp_data_ff;
   shl_pkg::rsp_type       rsp_in;
   logic                   accept;
   logic                   is_insert;
   logic                   is_read;
   logic                   is_clear;
   logic                   full;
   logic                   do_load;
   shl_pkg::entry_type     new_entry;
   shl_pkg::cell_link_type link [CAPACITY+1];
   shl_pkg::hit_ctrl_type  hit_ctrl;
   shl_pkg::hit_type       hit_next;
   shl_pkg::entry_type     read_entry;
   logic [EXT_W-1:0]       count_ext;
   logic [EXT_W-1:0]       next_count_ext;
   logic [EXT_W-1:0]       index_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_insert = (req_data.func == shl_pkg::FN_INSERT);
   assign is_read   = (req_data.func == shl_pkg::FN_READ);
   assign is_clear  = (req_data.func == shl_pkg::FN_CLEAR);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign do_load   = accept && is_insert && !full;

   assign new_entry.distance = req_data.distance;
   assign new_entry.shape_id = req_data.shape_id;

   // Head sees an always-smaller neighbor: takes the new word unless its own is smaller.
   assign link[0].entry = new_entry;
   assign link[0].gt    = 1'b1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      shl_pkg::cell_ctrl_type cell_ctrl;
      assign cell_ctrl.load     = do_load;
      assign cell_ctrl.occupied = (count_ff > CNT_W'(i));
      shl_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .new_entry (new_entry),
         .left      (link[i]),
         .right     (link[i+1])
      );
   end

   assign hit_ctrl.update = accept && is_insert;
   assign hit_ctrl.clear  = accept && is_clear;

   shl_hit_track u_hit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (hit_ctrl),
      .new_entry (new_entry),
      .hit_next  (hit_next)
   );

   always_comb begin
      priority if (accept && is_clear) begin
         count_in = '0;
      end else if (do_load) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign count_ext      = EXT_W'(count_ff);
   assign next_count_ext = EXT_W'(count_in);
   assign index_ext      = EXT_W'(req_data.read_index);

   always_comb begin
      read_entry = '0;
      for (int k = 0; k < RD_N; k++) begin
         if ((req_data.read_index == 4'(k)) && (index_ext < count_ext)) begin
            read_entry = link[k+1].entry;
         end
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.hit_valid      = hit_next.present;
      rsp_in.hit_distance   = hit_next.distance;
      rsp_in.hit_shape      = hit_next.shape_id;
      rsp_in.entry_count    = next_count_ext[4:0];
      rsp_in.overflow       = is_insert && full;
      if (is_read) begin
         rsp_in.entry_distance = read_entry.distance;
         rsp_in.entry_shape    = read_entry.shape_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.entry_count == count_ext[4:0]))
      else $error("pending result count differs from stored count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.overflow) |-> full)
      else $error("overflow reported while list not full");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(count_ff))
      else $error("list changed while result stalled");

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.hit_valid) |->
         ((rsp_data_ff.hit_distance == 32'sd0) && (rsp_data_ff.hit_shape == 16'd0)))
      else $error("hit fields nonzero without a hit");

endmodule
